>>> src/command_frame_check_and_relay_macros.svh
`ifndef COMMAND_FRAME_CHECK_AND_RELAY_MACROS_SVH
`define COMMAND_FRAME_CHECK_AND_RELAY_MACROS_SVH

// cond implies check in the same cycle
`define CFCR_ASSERT_SAME(lbl, cond, check, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (check)) else $error(msg);

// cond implies check in the next cycle
`define CFCR_ASSERT_NEXT(lbl, cond, check, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (check)) else $error(msg);

`endif

>>> src/cfcr_pkg.sv
`default_nettype none
package cfcr_pkg;

    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 8;
    localparam int DEC_BYTES = 6;
    localparam int QDEPTH    = 2;
    localparam int IDX_W     = 3;

    localparam logic [CFG_IDX_W-1:0] REG_START_CODE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_CODE     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_CODE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_CODE   = 8'd3;

    localparam logic [BYTE_W-1:0] RST_START_CODE   = 8'd2;
    localparam logic [BYTE_W-1:0] RST_END_CODE     = 8'd3;
    localparam logic [BYTE_W-1:0] RST_CONTROL_CODE = 8'd1;
    localparam logic [BYTE_W-1:0] RST_QUERY_CODE   = 8'd2;

    // index of the checksum byte in the relayed frame
    localparam logic [IDX_W-1:0] CTL_SUM_IDX = 3'd5;
    localparam logic [IDX_W-1:0] QRY_SUM_IDX = 3'd4;

    localparam logic [IDX_W-1:0] POS_START = 3'd0;
    localparam logic [IDX_W-1:0] POS_ID    = 3'd1;
    localparam logic [IDX_W-1:0] POS_CMD   = 3'd2;
    localparam logic [IDX_W-1:0] POS_DATA  = 3'd3;
    localparam logic [IDX_W-1:0] POS_ETX   = 3'd4;

    typedef logic [BYTE_W-1:0] t_byte;

    typedef struct packed {
        t_byte start_code;
        t_byte end_code;
        t_byte control_code;
        t_byte query_code;
    } t_cfg;

    typedef struct packed {
        t_byte stx;
        t_byte id;
        t_byte cmd;
        t_byte data;
        t_byte etx;
        logic  has_data;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage
`default_nettype wire

>>> src/cfcr_rx_if.sv
`default_nettype none
interface cfcr_rx_if;
    logic                 valid;
    logic                 ready;
    logic [7:0]           rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

>>> src/cfcr_tx_if.sv
`default_nettype none
interface cfcr_tx_if;
    logic                 valid;
    logic                 ready;
    logic [7:0]           tx_byte;
    logic                 frame_last;

    modport source (output valid, output tx_byte, output frame_last, input ready);
    modport sink   (input valid, input tx_byte, input frame_last, output ready);
endinterface
`default_nettype wire

>>> src/cfcr_cfg_if.sv
`default_nettype none
interface cfcr_cfg_if;
    logic                 valid;
    logic                 ready;
    logic [7:0]           index;
    logic [7:0]           data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> src/cfcr_regs.sv
`default_nettype none
module cfcr_regs (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_wr,
    input  wire [cfcr_pkg::CFG_IDX_W-1:0]     i_index,
    input  wire [cfcr_pkg::BYTE_W-1:0]        i_data,
    output cfcr_pkg::t_cfg                    o_cfg
);

    cfcr_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_code   <= cfcr_pkg::RST_START_CODE;
            r_cfg.end_code     <= cfcr_pkg::RST_END_CODE;
            r_cfg.control_code <= cfcr_pkg::RST_CONTROL_CODE;
            r_cfg.query_code   <= cfcr_pkg::RST_QUERY_CODE;
        end else if (i_wr) begin
            unique case (i_index)
                cfcr_pkg::REG_START_CODE:   r_cfg.start_code   <= i_data;
                cfcr_pkg::REG_END_CODE:     r_cfg.end_code     <= i_data;
                cfcr_pkg::REG_CONTROL_CODE: r_cfg.control_code <= i_data;
                cfcr_pkg::REG_QUERY_CODE:   r_cfg.query_code   <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

>>> src/cfcr_front.sv
`default_nettype none
module cfcr_front #(
    parameter int STORE_DEPTH = 8
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  cfcr_pkg::t_cfg               i_cfg,
    input  wire                          i_accept,
    input  wire [cfcr_pkg::BYTE_W-1:0]   i_byte,
    output logic                         o_push,
    output cfcr_pkg::t_job               o_job
);

    localparam int FW = $clog2(STORE_DEPTH + 1);

    // only the first bytes of a frame are ever decoded
    cfcr_pkg::t_byte r_store [cfcr_pkg::DEC_BYTES];
    logic [FW-1:0]   r_fill;
    logic            r_in_frame;
    logic            r_end_seen;

    cfcr_pkg::t_byte eff [cfcr_pkg::DEC_BYTES];
    logic            is_start;
    logic            can_push;
    logic            is_ctl;
    logic            is_qry;
    cfcr_pkg::t_byte sum_q;
    cfcr_pkg::t_byte sum_c;
    logic            good;

    assign is_start = (i_byte == i_cfg.start_code) && !r_in_frame;
    assign can_push = (r_fill < FW'(STORE_DEPTH));

    // store view including the byte just received
    always_comb begin
        for (int p = 0; p < cfcr_pkg::DEC_BYTES; p++) begin
            if (FW'(p) < r_fill) begin
                eff[p] = r_store[p];
            end else if (FW'(p) == r_fill) begin
                eff[p] = i_byte;
            end else begin
                eff[p] = '0;
            end
        end
    end

    assign is_ctl = (eff[2] == i_cfg.control_code);
    assign is_qry = (eff[2] == i_cfg.query_code);
    assign sum_q  = eff[0] + eff[1] + eff[2] + eff[3];
    assign sum_c  = sum_q + eff[4];

    always_comb begin
        if (is_ctl) begin
            good = (sum_c == eff[5]);
        end else begin
            good = is_qry && (sum_q == eff[4]);
        end
    end

    assign o_push = i_accept && r_end_seen && !is_start && good;

    always_comb begin
        o_job.stx      = i_cfg.start_code;
        o_job.id       = eff[1];
        o_job.cmd      = is_ctl ? i_cfg.control_code : i_cfg.query_code;
        o_job.data     = eff[3];
        o_job.etx      = i_cfg.end_code;
        o_job.has_data = is_ctl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_in_frame <= 1'b0;
            r_end_seen <= 1'b0;
        end else if (i_accept) begin
            if (is_start) begin
                r_fill     <= FW'(1);
                r_in_frame <= 1'b1;
            end else if (r_end_seen) begin
                r_fill     <= '0;
                r_in_frame <= 1'b0;
                r_end_seen <= 1'b0;
            end else begin
                if (can_push) begin
                    r_fill <= r_fill + FW'(1);
                end
                if (i_byte == i_cfg.end_code) begin
                    r_end_seen <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int p = 0; p < cfcr_pkg::DEC_BYTES; p++) begin
            if (i_accept) begin
                if (is_start) begin
                    if (p == 0) begin
                        r_store[p] <= i_byte;
                    end
                end else if (!r_end_seen && r_fill == FW'(p)) begin
                    r_store[p] <= i_byte;
                end
            end
        end
    end

endmodule
`default_nettype wire

>>> src/cfcr_queue.sv
`default_nettype none
module cfcr_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  cfcr_pkg::t_job      i_job,
    input  wire                 i_pop,
    output cfcr_pkg::t_job      o_job,
    output cfcr_pkg::t_q_stat   o_stat
);

    localparam int PW = (cfcr_pkg::QDEPTH > 1) ? $clog2(cfcr_pkg::QDEPTH) : 1;
    localparam int CW = $clog2(cfcr_pkg::QDEPTH + 1);

    cfcr_pkg::t_job r_mem [cfcr_pkg::QDEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           do_push;
    logic           do_pop;

    assign o_stat.full  = (r_count == CW'(cfcr_pkg::QDEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(cfcr_pkg::QDEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(cfcr_pkg::QDEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule
`default_nettype wire

>>> src/cfcr_back.sv
`default_nettype none
module cfcr_back (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_job_valid,
    input  cfcr_pkg::t_job               i_job,
    output logic                         o_pop,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic [cfcr_pkg::BYTE_W-1:0]  o_byte,
    output logic                         o_last
);

    logic [cfcr_pkg::IDX_W-1:0] r_idx;
    cfcr_pkg::t_byte            r_sum;
    logic                       r_valid;
    cfcr_pkg::t_byte            r_byte;
    logic                       r_last;

    logic                       load;
    logic                       is_sum;
    cfcr_pkg::t_byte            cur;

    assign load   = i_job_valid && (!r_valid || i_ready);
    assign is_sum = (r_idx == (i_job.has_data ? cfcr_pkg::CTL_SUM_IDX
                                              : cfcr_pkg::QRY_SUM_IDX));
    assign o_pop  = load && is_sum;

    always_comb begin
        unique case (r_idx)
            cfcr_pkg::POS_START: cur = i_job.stx;
            cfcr_pkg::POS_ID:    cur = i_job.id;
            cfcr_pkg::POS_CMD:   cur = i_job.cmd;
            cfcr_pkg::POS_DATA:  cur = i_job.has_data ? i_job.data : i_job.etx;
            cfcr_pkg::POS_ETX:   cur = i_job.etx;
            default:             cur = '0;
        endcase
        if (is_sum) begin
            cur = r_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_sum   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                if (is_sum) begin
                    r_idx <= '0;
                    r_sum <= '0;
                end else begin
                    r_idx <= r_idx + cfcr_pkg::IDX_W'(1);
                    r_sum <= r_sum + cur;
                end
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= cur;
            r_last <= is_sum;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

endmodule
`default_nettype wire

>>> src/command_frame_check_and_relay.sv
// A good frame is queued when its checksum byte is accepted; output bytes are registered.
// Throughput: one received byte per cycle while the two-frame job queue has room;
// output sends one byte per cycle while ready, 6 per control frame, 5 per state request.
// Reset: synchronous, active low; registers return to their defaults, store, queue
// and output stage are emptied.
`default_nettype none
`include "command_frame_check_and_relay_macros.svh"
module command_frame_check_and_relay #(
    parameter int STORE_DEPTH = 8
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    cfcr_rx_if.sink      i_rx,
    cfcr_tx_if.source    o_tx,
    cfcr_cfg_if.sink     i_cfg
);

    cfcr_pkg::t_cfg    cfg;
    cfcr_pkg::t_job    push_job;
    cfcr_pkg::t_job    head_job;
    cfcr_pkg::t_q_stat q_stat;
    logic              push;
    logic              pop;
    logic              rx_accept;

    assign i_cfg.ready = 1'b1;
    assign i_rx.ready  = !q_stat.full;
    assign rx_accept   = i_rx.valid && i_rx.ready;

    cfcr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg.valid && i_cfg.ready),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (cfg)
    );

    cfcr_front #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_accept (rx_accept),
        .i_byte   (i_rx.rx_byte),
        .o_push   (push),
        .o_job    (push_job)
    );

    cfcr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (q_stat)
    );

    cfcr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!q_stat.empty),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_valid     (o_tx.valid),
        .i_ready     (o_tx.ready),
        .o_byte      (o_tx.tx_byte),
        .o_last      (o_tx.frame_last)
    );

    `CFCR_ASSERT_SAME(a_no_push_full, push, !q_stat.full, "job pushed into full queue")
    `CFCR_ASSERT_SAME(a_no_pop_empty, pop, !q_stat.empty, "job popped from empty queue")
    `CFCR_ASSERT_NEXT(a_pop_last, pop, o_tx.valid && o_tx.frame_last, "pop without last byte")

endmodule
`default_nettype wire

>>> test/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cfcr_pkg::*;

    localparam int STORE_DEPTH   = 8;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int CFG_IDX_MAX   = (1 << CFG_IDX_W) - 1;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        t_byte tx_byte;
        logic  frame_last;
    } t_relay_beat;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    cfcr_rx_if  rx_bus();
    cfcr_tx_if  tx_bus();
    cfcr_cfg_if cfg_bus();

    logic                 rx_valid_r  = 1'b0;
    t_byte                rx_byte_r   = '0;
    logic                 tx_ready_r  = 1'b0;
    logic                 cfg_valid_r = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index_r = '0;
    t_byte                cfg_data_r  = '0;

    assign rx_bus.valid   = rx_valid_r;
    assign rx_bus.rx_byte = rx_byte_r;
    assign tx_bus.ready   = tx_ready_r;
    assign cfg_bus.valid  = cfg_valid_r;
    assign cfg_bus.index  = cfg_index_r;
    assign cfg_bus.data   = cfg_data_r;

    command_frame_check_and_relay #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_bus),
        .o_tx    (tx_bus),
        .i_cfg   (cfg_bus)
    );

    // frame tracking model
    t_cfg  codes = '{RST_START_CODE, RST_END_CODE, RST_CONTROL_CODE, RST_QUERY_CODE};
    t_byte frame_mem [STORE_DEPTH] = '{default: '0};
    int    fill_cnt   = 0;
    bit    frame_open = 1'b0;
    bit    sum_next   = 1'b0;

    t_relay_beat expected_relay_q[$];
    t_byte       byte_q[$];
    t_relay_beat want;

    int  rx_gap         = 0;
    int  tx_stall       = 0;
    bit  rx_idle_on     = 1'b1;
    bit  tx_idle_on     = 1'b1;
    int  bytes_queued   = 0;
    int  rx_accepted    = 0;
    int  relayed_bytes  = 0;
    int  relayed_frames = 0;
    int  mismatches     = 0;
    int  settings_used  = 1;
    int  cycle_count    = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic void clear_store();
        foreach (frame_mem[i]) frame_mem[i] = '0;
        fill_cnt = 0;
    endfunction

    function automatic void store_byte(input t_byte b);
        if (fill_cnt < STORE_DEPTH) begin
            frame_mem[fill_cnt] = b;
            fill_cnt++;
        end
    endfunction

    function automatic t_byte stored(input int pos);
        return (pos < fill_cnt) ? frame_mem[pos] : '0;
    endfunction

    function automatic void check_stored_frame();
        t_byte cmd;
        t_byte sum;
        t_byte relay[$];
        cmd = stored(POS_CMD);
        if (cmd == codes.control_code) begin
            sum = stored(POS_START) + stored(POS_ID) + cmd + stored(POS_DATA) + stored(POS_ETX);
            if (sum == stored(CTL_SUM_IDX))
                relay = '{codes.start_code, stored(POS_ID), codes.control_code,
                          stored(POS_DATA), codes.end_code};
        end else if (cmd == codes.query_code) begin
            // state request: end byte sits where a control frame has its data
            sum = stored(POS_START) + stored(POS_ID) + cmd + stored(POS_DATA);
            if (sum == stored(QRY_SUM_IDX))
                relay = '{codes.start_code, stored(POS_ID), codes.query_code, codes.end_code};
        end
        if (relay.size() != 0) begin
            sum = '0;
            foreach (relay[k]) begin
                sum += relay[k];
                expected_relay_q.push_back('{tx_byte: relay[k], frame_last: 1'b0});
            end
            expected_relay_q.push_back('{tx_byte: sum, frame_last: 1'b1});
        end
    endfunction

    function automatic void absorb_rx_byte(input t_byte b);
        store_byte(b);
        if (b == codes.start_code && !frame_open) begin
            clear_store();
            store_byte(b);
            frame_open = 1'b1;
        end else if (sum_next) begin
            check_stored_frame();
            clear_store();
            sum_next   = 1'b0;
            frame_open = 1'b0;
        end else if (b == codes.end_code) begin
            sum_next = 1'b1;
        end
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 93) return $urandom_range(3, 6);
        return $urandom_range(10, 40);
    endfunction

    function automatic void flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] relay mismatch: %s", $realtime, what);
    endfunction

    // rx driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rx_valid_r && rx_bus.ready) begin
                absorb_rx_byte(rx_byte_r);
                rx_accepted++;
            end
            if (!rx_valid_r || rx_bus.ready) begin
                if (rx_gap > 0) begin
                    rx_gap     <= rx_gap - 1;
                    rx_valid_r <= 1'b0;
                end else if (byte_q.size() != 0) begin
                    rx_valid_r <= 1'b1;
                    rx_byte_r  <= byte_q.pop_front();
                    rx_gap     <= (rx_idle_on && $urandom_range(0, 99) < 40) ? gap_len() : 0;
                end else begin
                    rx_valid_r <= 1'b0;
                end
            end
        end
    end

    // tx monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (tx_bus.valid && tx_ready_r) begin
                if (expected_relay_q.size() == 0) begin
                    flag_mismatch($sformatf("unexpected transaction tx_byte %02h frame_last %0b",
                                            tx_bus.tx_byte, tx_bus.frame_last));
                end else begin
                    want = expected_relay_q.pop_front();
                    if (want.tx_byte !== tx_bus.tx_byte || want.frame_last !== tx_bus.frame_last)
                        flag_mismatch($sformatf("tx_byte exp %02h got %02h, frame_last exp %0b got %0b",
                                                want.tx_byte, tx_bus.tx_byte,
                                                want.frame_last, tx_bus.frame_last));
                end
                relayed_bytes++;
                if (tx_bus.frame_last === 1'b1) relayed_frames++;
            end
            if (tx_stall > 0) begin
                tx_stall   <= tx_stall - 1;
                tx_ready_r <= 1'b0;
            end else if (tx_idle_on && $urandom_range(0, 99) < 25) begin
                tx_stall   <= gap_len() - 1;
                tx_ready_r <= 1'b0;
            end else begin
                tx_ready_r <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d relay bytes still expected",
                     cycle_count, expected_relay_q.size());
            $display("FAIL");
            $finish;
        end
    end

    function automatic void send(input t_byte b);
        byte_q.push_back(b);
        bytes_queued++;
    endfunction

    function automatic t_byte rand_content();
        t_byte b;
        do b = t_byte'($urandom_range(0, 255)); while (b == codes.end_code);
        return b;
    endfunction

    function automatic void queue_frame(input t_byte id, input t_byte cmd, input t_byte data,
                                        input bit with_data, input bit bad_sum);
        t_byte sum;
        sum = codes.start_code + id + cmd + codes.end_code + (with_data ? data : t_byte'(0));
        if (bad_sum) sum += t_byte'($urandom_range(1, 255));
        send(codes.start_code);
        send(id);
        send(cmd);
        if (with_data) send(data);
        send(codes.end_code);
        send(sum);
    endfunction

    // leaves the receiver outside a frame from any state; needs start != end
    function automatic void resync();
        t_byte x;
        do x = t_byte'($urandom_range(0, 255));
        while (x == codes.start_code || x == codes.end_code);
        send(codes.end_code);
        send(x);
    endfunction

    // overfilled control frame whose first six stored bytes still check out
    function automatic void queue_long_frame();
        t_byte id;
        t_byte data;
        t_byte x;
        int    extra;
        id   = rand_content();
        data = rand_content();
        do x = rand_content();
        while (t_byte'(codes.start_code + id + codes.control_code + data + x) == codes.end_code);
        extra = $urandom_range(1, 6);
        send(codes.start_code);
        send(id);
        send(codes.control_code);
        send(data);
        send(x);
        send(codes.start_code + id + codes.control_code + data + x);
        repeat (extra) send(rand_content());
        send(codes.end_code);
        send(t_byte'($urandom_range(0, 255)));
    endfunction

    task automatic drain();
        do @(negedge i_clk);
        while (byte_q.size() != 0 || rx_valid_r || expected_relay_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_byte val);
        cfg_valid_r <= 1'b1;
        cfg_index_r <= idx;
        cfg_data_r  <= val;
        do @(posedge i_clk); while (!cfg_bus.ready);
        case (idx)
            REG_START_CODE:   codes.start_code   = val;
            REG_END_CODE:     codes.end_code     = val;
            REG_CONTROL_CODE: codes.control_code = val;
            REG_QUERY_CODE:   codes.query_code   = val;
            default: ;
        endcase
    endtask

    task automatic set_codes(input t_byte s, input t_byte e, input t_byte c, input t_byte q);
        write_reg(CFG_IDX_W'($urandom_range(REG_QUERY_CODE + 1, CFG_IDX_MAX)),
                  t_byte'($urandom_range(0, 255)));
        write_reg(REG_START_CODE, s);
        write_reg(REG_END_CODE, e);
        write_reg(REG_CONTROL_CODE, c);
        write_reg(REG_QUERY_CODE, q);
        cfg_valid_r <= 1'b0;
        settings_used++;
    endtask

    task automatic random_burst(input int n_items);
        int    first;
        int    pick;
        bit    held;
        t_byte cmd;
        first = bytes_queued;
        held  = 1'b0;
        while (bytes_queued - first < n_items) begin
            if (!held && bytes_queued - first >= n_items / 2) begin
                drain();
                held = 1'b1;
            end
            rx_idle_on <= ($urandom_range(0, 4) != 0);
            tx_idle_on <= ($urandom_range(0, 4) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                queue_frame(rand_content(), codes.control_code, rand_content(), 1'b1, 1'b0);
            end else if (pick < 73) begin
                queue_frame(rand_content(), codes.query_code, '0, 1'b0, 1'b0);
            end else if (pick < 80) begin
                if ($urandom_range(0, 1))
                    queue_frame(rand_content(), codes.control_code, rand_content(), 1'b1, 1'b1);
                else
                    queue_frame(rand_content(), codes.query_code, '0, 1'b0, 1'b1);
            end else if (pick < 86) begin
                do cmd = t_byte'($urandom_range(0, 255));
                while (cmd == codes.control_code || cmd == codes.query_code ||
                       cmd == codes.end_code);
                queue_frame(rand_content(), cmd, rand_content(), bit'($urandom_range(0, 1)), 1'b0);
            end else if (pick < 93) begin
                repeat ($urandom_range(1, 10)) send(t_byte'($urandom_range(0, 255)));
                resync();
            end else begin
                queue_long_frame();
            end
            while (byte_q.size() > 6) @(posedge i_clk);
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default codes: extremes, each frame kind, bad sum, stray end byte, overfill
        queue_frame(8'h00, codes.control_code, 8'hFF, 1'b1, 1'b0);
        queue_frame(8'hFF, codes.query_code, '0, 1'b0, 1'b0);
        queue_frame(8'h5A, codes.control_code, 8'hA5, 1'b1, 1'b1);
        send(codes.end_code);
        send(8'h10);
        send(codes.start_code);
        send(codes.start_code);
        send(codes.control_code);
        send(8'h10);
        send(8'h20);
        send(codes.start_code + codes.start_code + codes.control_code + 8'h10 + 8'h20);
        send(8'h99);
        send(8'hAA);
        send(codes.end_code);
        send(8'h00);
        drain();
        random_burst(8);
        drain();

        // extreme codes; stray end byte then a byte that completes a zero-padded control frame
        set_codes(8'h00, 8'hFF, 8'h00, 8'hFE);
        send(codes.end_code);
        send(t_byte'(8'h00 - codes.end_code));
        random_burst(12);
        drain();

        // control and query share one code
        set_codes(8'hA5, 8'h5A, 8'h55, 8'h55);
        queue_frame(8'h33, codes.query_code, '0, 1'b0, 1'b0);
        queue_frame(rand_content(), codes.control_code, rand_content(), 1'b1, 1'b0);
        random_burst(8);
        drain();

        begin
            t_byte s;
            t_byte e;
            t_byte c;
            t_byte q;
            s = t_byte'($urandom_range(0, 255));
            do e = t_byte'($urandom_range(0, 255)); while (e == s);
            do c = t_byte'($urandom_range(0, 255)); while (c == e);
            do q = t_byte'($urandom_range(0, 255)); while (q == e);
            set_codes(s, e, c, q);
        end
        random_burst(16);
        drain();

        $display("Sent %0d bytes under %0d code settings; %0d bytes relayed in %0d frames",
                 rx_accepted, settings_used, relayed_bytes, relayed_frames);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0 && expected_relay_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
